@@ rtl/core/jpeg_native_scale_nearest_resampler_assert.svh @@
// Assertion macros shared by the resampler RTL
`ifndef JPEG_NATIVE_SCALE_NEAREST_RESAMPLER_ASSERT_SVH
`define JPEG_NATIVE_SCALE_NEAREST_RESAMPLER_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define JNSR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define JNSR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/jnsr_pkg.sv @@
// Shared types and constants of the native-scale nearest resampler
package jnsr_pkg;

    localparam int unsigned DIM_W  = 16;
    localparam int unsigned TGT_W  = 13;
    localparam int unsigned ADDR_W = 24;
    localparam int unsigned PIX_W  = 16;
    localparam int unsigned PROD_W = DIM_W + TGT_W;
    localparam int unsigned NUM_W  = PROD_W + 2;
    localparam int unsigned DEN_W  = DIM_W + 1;
    localparam int unsigned QUO_W  = TGT_W;
    localparam int unsigned DSH_W  = DEN_W + QUO_W - 1;
    localparam int unsigned CNT_W  = $clog2(QUO_W);

    localparam logic [TGT_W-1:0] MAX_TARGET_DIM = 13'd4096;

    localparam logic [1:0] CFG_SOURCE_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_SOURCE_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_TARGET_WIDTH  = 2'd2;
    localparam logic [1:0] CFG_TARGET_HEIGHT = 2'd3;

    localparam logic REQ_FRAME = 1'b0;
    localparam logic REQ_PIXEL = 1'b1;

    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_WRITE  = 1'b1;

    localparam logic [1:0] SCALE_FULL    = 2'd0;
    localparam logic [1:0] SCALE_HALF    = 2'd1;
    localparam logic [1:0] SCALE_QUARTER = 2'd2;
    localparam logic [1:0] SCALE_EIGHTH  = 2'd3;

    localparam logic [1:0] MUL_SPAN  = 2'd0;
    localparam logic [1:0] MUL_TOTAL = 2'd1;
    localparam logic [1:0] MUL_BASE  = 2'd2;

    // span bounds: first target index of p, first target index of p+1
    localparam logic [1:0] PH_X_FIRST = 2'd0;
    localparam logic [1:0] PH_X_END   = 2'd1;
    localparam logic [1:0] PH_Y_FIRST = 2'd2;
    localparam logic [1:0] PH_Y_END   = 2'd3;

    typedef struct packed {
        logic             req_type;
        logic [DIM_W-1:0] pixel_x;
        logic [DIM_W-1:0] pixel_y;
        logic [PIX_W-1:0] pixel_value;
    } t_in_item;

    typedef struct packed {
        logic              result_kind;
        logic [1:0]        scale_code;
        logic [DIM_W-1:0]  decoded_width_out;
        logic [DIM_W-1:0]  decoded_height_out;
        logic [ADDR_W-1:0] target_address;
        logic [PIX_W-1:0]  pixel_out;
        logic              last;
        logic              truncated;
    } t_out_item;

    typedef struct packed {
        logic       load_in;
        logic       set_scale;
        logic       push_report;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       div_start;
        logic       store_q;
        logic [1:0] phase;
        logic       set_emit;
        logic       init_addr;
        logic       push_write;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic drop;
        logic div_done;
        logic total_zero;
        logic last_write;
    } t_status;

endpackage

@@ rtl/core/jnsr_div.sv @@
// Restoring divider, one quotient bit per cycle
module jnsr_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [jnsr_pkg::NUM_W-1:0]    i_num,
    input  logic [jnsr_pkg::DEN_W-1:0]    i_den,
    output logic                          o_done,
    output logic [jnsr_pkg::QUO_W-1:0]    o_quot
);

    logic [jnsr_pkg::NUM_W-1:0] r_rem;
    logic [jnsr_pkg::DSH_W-1:0] r_dsh;
    logic [jnsr_pkg::QUO_W-1:0] r_quot;
    logic [jnsr_pkg::CNT_W-1:0] r_cnt;
    logic                       r_busy;
    logic                       r_done;

    logic [jnsr_pkg::NUM_W-1:0] w_dsh_ext;
    logic                       w_ge;

    assign w_dsh_ext = {{(jnsr_pkg::NUM_W - jnsr_pkg::DSH_W){1'b0}}, r_dsh};
    assign w_ge      = (r_rem >= w_dsh_ext);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == '0)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num;
            r_dsh  <= {i_den, {(jnsr_pkg::QUO_W - 1){1'b0}}};
            r_quot <= '0;
            r_cnt  <= jnsr_pkg::CNT_W'(jnsr_pkg::QUO_W - 1);
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem <= r_rem - w_dsh_ext;
            end
            r_quot <= {r_quot[jnsr_pkg::QUO_W-2:0], w_ge};
            r_dsh  <= r_dsh >> 1;
            r_cnt  <= r_cnt - jnsr_pkg::CNT_W'(1);
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

@@ rtl/core/jnsr_ctrl.sv @@
// Sequencer for frame reports, span divisions and write beats
`include "jpeg_native_scale_nearest_resampler_assert.svh"

module jnsr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_req_type,
    output logic              o_in_ready,
    input  jnsr_pkg::t_status i_status,
    output jnsr_pkg::t_cmd    o_cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SCALE  = 4'd1;
    localparam logic [3:0] S_REPORT = 4'd2;
    localparam logic [3:0] S_CHECK  = 4'd3;
    localparam logic [3:0] S_MUL    = 4'd4;
    localparam logic [3:0] S_DIV    = 4'd5;
    localparam logic [3:0] S_WAIT   = 4'd6;
    localparam logic [3:0] S_TOTAL  = 4'd7;
    localparam logic [3:0] S_TRUNC  = 4'd8;
    localparam logic [3:0] S_BASE   = 4'd9;
    localparam logic [3:0] S_ADDR   = 4'd10;
    localparam logic [3:0] S_WRITE  = 4'd11;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic [1:0] r_phase;
    logic [1:0] n_phase;

    jnsr_pkg::t_cmd w_cmd;
    logic           w_ready;

    always_comb begin
        w_cmd       = '0;
        w_cmd.phase = r_phase;
        w_ready     = 1'b0;
        n_state     = r_state;
        n_phase     = r_phase;
        case (r_state)
            S_IDLE: begin
                w_ready = 1'b1;
                if (i_in_valid) begin
                    w_cmd.load_in = 1'b1;
                    n_state = (i_req_type == jnsr_pkg::REQ_FRAME) ? S_SCALE : S_CHECK;
                end
            end
            S_SCALE: begin
                w_cmd.set_scale = 1'b1;
                n_state = S_REPORT;
            end
            S_REPORT: begin
                if (i_status.out_free) begin
                    w_cmd.push_report = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_CHECK: begin
                if (i_status.drop) begin
                    n_state = S_IDLE;
                end else begin
                    n_phase = jnsr_pkg::PH_X_FIRST;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                w_cmd.mul_en  = 1'b1;
                w_cmd.mul_sel = jnsr_pkg::MUL_SPAN;
                n_state = S_DIV;
            end
            S_DIV: begin
                w_cmd.div_start = 1'b1;
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (i_status.div_done) begin
                    w_cmd.store_q = 1'b1;
                    if (r_phase == jnsr_pkg::PH_Y_END) begin
                        n_state = S_TOTAL;
                    end else begin
                        n_phase = r_phase + 2'd1;
                        n_state = S_MUL;
                    end
                end
            end
            S_TOTAL: begin
                w_cmd.mul_en  = 1'b1;
                w_cmd.mul_sel = jnsr_pkg::MUL_TOTAL;
                n_state = S_TRUNC;
            end
            S_TRUNC: begin
                w_cmd.set_emit = 1'b1;
                n_state = i_status.total_zero ? S_IDLE : S_BASE;
            end
            S_BASE: begin
                w_cmd.mul_en  = 1'b1;
                w_cmd.mul_sel = jnsr_pkg::MUL_BASE;
                n_state = S_ADDR;
            end
            S_ADDR: begin
                w_cmd.init_addr = 1'b1;
                n_state = S_WRITE;
            end
            S_WRITE: begin
                if (i_status.out_free) begin
                    w_cmd.push_write = 1'b1;
                    if (i_status.last_write) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= jnsr_pkg::PH_X_FIRST;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

    assign o_cmd      = w_cmd;
    assign o_in_ready = w_ready;

    `JNSR_ASSERT_IMP(a_push_has_room, i_clk, i_rst_n, o_cmd.push_write || o_cmd.push_report, i_status.out_free, "beat pushed into a full output register")
    `JNSR_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "ready held high after an accepted beat")
    `JNSR_ASSERT_NXT(a_div_not_instant, i_clk, i_rst_n, o_cmd.div_start, !i_status.div_done, "divider finished one cycle after start")

endmodule

@@ rtl/core/jnsr_dp.sv @@
// Datapath: config, decoded size, span math, address walk and output register
`include "jpeg_native_scale_nearest_resampler_assert.svh"

module jnsr_dp #(
    parameter int unsigned MAX_WRITES_PER_PIXEL = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  jnsr_pkg::t_cmd                i_cmd,
    output jnsr_pkg::t_status             o_status,
    input  jnsr_pkg::t_in_item            i_in_data,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_idx,
    input  logic [jnsr_pkg::DIM_W-1:0]    i_cfg_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output jnsr_pkg::t_out_item           o_out_data
);

    localparam int unsigned KW = $clog2(MAX_WRITES_PER_PIXEL + 1);

    localparam int unsigned DW = jnsr_pkg::DIM_W;
    localparam int unsigned TW = jnsr_pkg::TGT_W;
    localparam int unsigned QW = jnsr_pkg::QUO_W;
    localparam int unsigned AW = jnsr_pkg::ADDR_W;
    localparam int unsigned PW = jnsr_pkg::PROD_W;

    function automatic logic [TW-1:0] fix_target(input logic [TW-1:0] t);
        logic [TW-1:0] r;
        r = t;
        if (t == '0) begin
            r = TW'(1);
        end else if (t > jnsr_pkg::MAX_TARGET_DIM) begin
            r = jnsr_pkg::MAX_TARGET_DIM;
        end
        return r;
    endfunction

    // configuration
    logic [DW-1:0] r_sw, r_sh;
    logic [TW-1:0] r_tw, r_th;

    // frame state
    logic [DW-1:0] r_dw, r_dh;
    logic [1:0]    r_scale;

    // item and span working registers
    logic [DW-1:0]               r_px, r_py;
    logic [jnsr_pkg::PIX_W-1:0]  r_pv;
    logic [PW-1:0]               r_prod;
    logic [QW-1:0]               r_x0, r_x1, r_y0, r_y1;
    logic [QW-1:0]               r_xi;
    logic [KW-1:0]               r_k, r_emit;
    logic                        r_trunc;
    logic [AW-1:0]               r_addr, r_row;

    logic                        r_o_valid;
    jnsr_pkg::t_out_item         r_o;

    // fixed-up sizes
    logic [DW-1:0] w_sw, w_sh;
    logic [TW-1:0] w_tw, w_th;
    logic [DW-1:0] w_tw16, w_th16;
    logic [DW:0]   w_sum_w8, w_sum_w4, w_sum_w2, w_sum_h8, w_sum_h4, w_sum_h2;
    logic [DW-1:0] w_w8, w_w4, w_w2, w_h8, w_h4, w_h2;
    logic          w_fit8, w_fit4, w_fit2;

    // span math
    logic          w_is_y, w_is_end;
    logic [DW-1:0] w_p_base, w_p, w_d;
    logic [TW-1:0] w_t;
    logic [DW-1:0] w_mul_a;
    logic [TW-1:0] w_mul_b;
    logic [PW-1:0] w_mul;
    logic [jnsr_pkg::NUM_W-1:0] w_num;
    logic [jnsr_pkg::DEN_W-1:0] w_den;
    logic          w_div_done;
    logic [QW-1:0] w_quot;
    logic [QW-1:0] w_nx, w_ny;
    logic          w_trunc;
    logic          w_last_write;
    logic          w_row_end;
    logic [AW-1:0] w_start, w_tw_a;
    logic          w_out_free;

    assign w_sw   = (r_sw == '0) ? DW'(1) : r_sw;
    assign w_sh   = (r_sh == '0) ? DW'(1) : r_sh;
    assign w_tw   = fix_target(r_tw);
    assign w_th   = fix_target(r_th);
    assign w_tw16 = {{(DW - TW){1'b0}}, w_tw};
    assign w_th16 = {{(DW - TW){1'b0}}, w_th};

    // ceil(s / 2^k) as add then shift
    assign w_sum_w8 = {1'b0, w_sw} + 17'd7;
    assign w_sum_w4 = {1'b0, w_sw} + 17'd3;
    assign w_sum_w2 = {1'b0, w_sw} + 17'd1;
    assign w_sum_h8 = {1'b0, w_sh} + 17'd7;
    assign w_sum_h4 = {1'b0, w_sh} + 17'd3;
    assign w_sum_h2 = {1'b0, w_sh} + 17'd1;
    assign w_w8 = {2'b00, w_sum_w8[DW:3]};
    assign w_w4 = {1'b0, w_sum_w4[DW:2]};
    assign w_w2 = w_sum_w2[DW:1];
    assign w_h8 = {2'b00, w_sum_h8[DW:3]};
    assign w_h4 = {1'b0, w_sum_h4[DW:2]};
    assign w_h2 = w_sum_h2[DW:1];
    assign w_fit8 = (w_w8 >= w_tw16) && (w_h8 >= w_th16);
    assign w_fit4 = (w_w4 >= w_tw16) && (w_h4 >= w_th16);
    assign w_fit2 = (w_w2 >= w_tw16) && (w_h2 >= w_th16);

    // first target index sampling p is floor((2*T*p + D - 1) / (2*D))
    assign w_is_y   = (i_cmd.phase == jnsr_pkg::PH_Y_FIRST) ||
                      (i_cmd.phase == jnsr_pkg::PH_Y_END);
    assign w_is_end = (i_cmd.phase == jnsr_pkg::PH_X_END) ||
                      (i_cmd.phase == jnsr_pkg::PH_Y_END);
    assign w_p_base = w_is_y ? r_py : r_px;
    assign w_p      = w_is_end ? (w_p_base + DW'(1)) : w_p_base;
    assign w_d      = w_is_y ? r_dh : r_dw;
    assign w_t      = w_is_y ? w_th : w_tw;

    assign w_nx = r_x1 - r_x0;
    assign w_ny = r_y1 - r_y0;

    always_comb begin
        case (i_cmd.mul_sel)
            jnsr_pkg::MUL_SPAN: begin
                w_mul_a = w_p;
                w_mul_b = w_t;
            end
            jnsr_pkg::MUL_TOTAL: begin
                w_mul_a = {{(DW - QW){1'b0}}, w_nx};
                w_mul_b = w_ny;
            end
            jnsr_pkg::MUL_BASE: begin
                w_mul_a = {{(DW - QW){1'b0}}, r_y0};
                w_mul_b = w_tw;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_mul = {{(PW - DW){1'b0}}, w_mul_a} * {{(PW - TW){1'b0}}, w_mul_b};
    assign w_num = {1'b0, r_prod, 1'b0} + {{(jnsr_pkg::NUM_W - DW){1'b0}}, w_d}
                   - jnsr_pkg::NUM_W'(1);
    assign w_den = {w_d, 1'b0};

    jnsr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign w_trunc      = (r_prod > PW'(MAX_WRITES_PER_PIXEL));
    assign w_last_write = ((r_k + KW'(1)) == r_emit);
    assign w_row_end    = ((r_xi + QW'(1)) == w_nx);
    assign w_tw_a       = {{(AW - TW){1'b0}}, w_tw};
    assign w_start      = r_prod[AW-1:0] + {{(AW - QW){1'b0}}, r_x0};
    assign w_out_free   = !r_o_valid || i_out_ready;

    // configuration and frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw    <= DW'(1);
            r_sh    <= DW'(1);
            r_tw    <= TW'(1);
            r_th    <= TW'(1);
            r_dw    <= DW'(1);
            r_dh    <= DW'(1);
            r_scale <= jnsr_pkg::SCALE_FULL;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    jnsr_pkg::CFG_SOURCE_WIDTH:  r_sw <= i_cfg_data;
                    jnsr_pkg::CFG_SOURCE_HEIGHT: r_sh <= i_cfg_data;
                    jnsr_pkg::CFG_TARGET_WIDTH:  r_tw <= i_cfg_data[TW-1:0];
                    jnsr_pkg::CFG_TARGET_HEIGHT: r_th <= i_cfg_data[TW-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.set_scale) begin
                // coarsest native scale that still covers the target
                if (w_fit8) begin
                    r_scale <= jnsr_pkg::SCALE_EIGHTH;
                    r_dw    <= w_w8;
                    r_dh    <= w_h8;
                end else if (w_fit4) begin
                    r_scale <= jnsr_pkg::SCALE_QUARTER;
                    r_dw    <= w_w4;
                    r_dh    <= w_h4;
                end else if (w_fit2) begin
                    r_scale <= jnsr_pkg::SCALE_HALF;
                    r_dw    <= w_w2;
                    r_dh    <= w_h2;
                end else begin
                    r_scale <= jnsr_pkg::SCALE_FULL;
                    r_dw    <= w_sw;
                    r_dh    <= w_sh;
                end
            end
        end
    end

    // item working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_px <= i_in_data.pixel_x;
            r_py <= i_in_data.pixel_y;
            r_pv <= i_in_data.pixel_value;
        end
        if (i_cmd.mul_en) begin
            r_prod <= w_mul;
        end
        if (i_cmd.store_q) begin
            case (i_cmd.phase)
                jnsr_pkg::PH_X_FIRST: r_x0 <= w_quot;
                jnsr_pkg::PH_X_END:   r_x1 <= w_quot;
                jnsr_pkg::PH_Y_FIRST: r_y0 <= w_quot;
                jnsr_pkg::PH_Y_END:   r_y1 <= w_quot;
                default: begin
                end
            endcase
        end
        if (i_cmd.set_emit) begin
            r_trunc <= w_trunc;
            r_emit  <= w_trunc ? KW'(MAX_WRITES_PER_PIXEL) : r_prod[KW-1:0];
        end
        if (i_cmd.init_addr) begin
            r_addr <= w_start;
            r_row  <= w_start;
            r_xi   <= '0;
            r_k    <= '0;
        end else if (i_cmd.push_write) begin
            r_k <= r_k + KW'(1);
            if (w_row_end) begin
                r_xi   <= '0;
                r_row  <= r_row + w_tw_a;
                r_addr <= r_row + w_tw_a;
            end else begin
                r_xi   <= r_xi + QW'(1);
                r_addr <= r_addr + AW'(1);
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.push_report || i_cmd.push_write) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push_report) begin
            r_o.result_kind        <= jnsr_pkg::KIND_REPORT;
            r_o.scale_code         <= r_scale;
            r_o.decoded_width_out  <= r_dw;
            r_o.decoded_height_out <= r_dh;
            r_o.target_address     <= '0;
            r_o.pixel_out          <= '0;
            r_o.last               <= 1'b1;
            r_o.truncated          <= 1'b0;
        end else if (i_cmd.push_write) begin
            r_o.result_kind        <= jnsr_pkg::KIND_WRITE;
            r_o.scale_code         <= r_scale;
            r_o.decoded_width_out  <= r_dw;
            r_o.decoded_height_out <= r_dh;
            r_o.target_address     <= r_addr;
            r_o.pixel_out          <= r_pv;
            r_o.last               <= w_last_write;
            r_o.truncated          <= r_trunc;
        end
    end

    assign o_status.out_free   = w_out_free;
    assign o_status.drop       = (r_px >= r_dw) || (r_py >= r_dh);
    assign o_status.div_done   = w_div_done;
    assign o_status.total_zero = (r_prod == '0);
    assign o_status.last_write = w_last_write;

    assign o_out_valid = r_o_valid;
    assign o_out_data  = r_o;

    `JNSR_ASSERT_IMP(a_write_count_in_range, i_clk, i_rst_n, i_cmd.push_write, r_k < r_emit, "write beat beyond the emit count")
    `JNSR_ASSERT_IMP(a_column_in_span, i_clk, i_rst_n, i_cmd.push_write, r_xi < w_nx, "column walk left the span")
    `JNSR_ASSERT_IMP(a_span_within_target, i_clk, i_rst_n, i_cmd.store_q, w_quot <= w_t, "span bound beyond target size")

endmodule

@@ rtl/core/jpeg_native_scale_nearest_resampler.sv @@
// Frame-start scale pick and JPEG pixel scatter into a nearest-neighbor target buffer
// Frame start: scale set, report pushed once the output register is free, then ready.
// Pixel: four runs of the 13-step span divider before the first write beat, then one
//   write per cycle while the sink takes beats.
// Dropped pixel (outside the decoded size): back to idle after the check state.
// Reset (i_rst_n low, synchronous): sizes 1, decoded size 1x1, full scale, no beat pending.
module jpeg_native_scale_nearest_resampler #(
    parameter int unsigned MAX_WRITES_PER_PIXEL = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  jnsr_pkg::t_in_item            i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output jnsr_pkg::t_out_item           o_out_data,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_idx,
    input  logic [jnsr_pkg::DIM_W-1:0]    i_cfg_data
);

    jnsr_pkg::t_cmd    w_cmd;
    jnsr_pkg::t_status w_status;

    jnsr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_in_data.req_type),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    jnsr_dp #(
        .MAX_WRITES_PER_PIXEL (MAX_WRITES_PER_PIXEL)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

@@ verif/tb.sv @@
// Self-checking testbench for the native-scale nearest-neighbor resampler
`timescale 1ns / 1ps

module tb;

    localparam int unsigned WRITE_CAP      = 64;
    localparam int unsigned HOLD_CYCLES    = 400;
    localparam int unsigned SETTLE_CYCLES  = 150;
    localparam int unsigned WATCHDOG_LIMIT = 4000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                in_valid = 1'b0;
    logic                in_ready;
    jnsr_pkg::t_in_item  in_data = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    jnsr_pkg::t_out_item out_data;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_idx = jnsr_pkg::CFG_SOURCE_WIDTH;
    logic [15:0] cfg_data = '0;

    // stimulus and expectations
    jnsr_pkg::t_in_item  decoder_items[$];
    jnsr_pkg::t_out_item beats_due[$];

    // predictor copy of configuration and frame state
    logic [15:0] src_w = 16'd1;
    logic [15:0] src_h = 16'd1;
    logic [12:0] tgt_w = 13'd1;
    logic [12:0] tgt_h = 13'd1;
    logic [15:0] dec_w = 16'd1;
    logic [15:0] dec_h = 16'd1;
    logic [1:0]  scale_now = jnsr_pkg::SCALE_FULL;

    int unsigned in_idle_pct = 0;
    int unsigned out_stall_pct = 0;
    logic        pressure_go = 1'b0;
    logic        hold_out = 1'b0;

    int unsigned errors = 0;
    int unsigned items_in = 0;
    int unsigned frames_seen = 0;
    int unsigned writes_seen = 0;
    int unsigned cut_writes_seen = 0;
    int unsigned quiet_cycles = 0;

    jpeg_native_scale_nearest_resampler #(
        .MAX_WRITES_PER_PIXEL(WRITE_CAP)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    function automatic int unsigned clamp_target(input logic [12:0] t);
        if (t == 13'd0)
            return 1;
        if (t > jnsr_pkg::MAX_TARGET_DIM)
            return 32'(jnsr_pkg::MAX_TARGET_DIM);
        return 32'(t);
    endfunction

    // coarsest native scale whose rounded-up size still covers the target
    task automatic pick_scale(input logic [15:0] sw_raw, input logic [15:0] sh_raw,
                              input logic [12:0] tw_raw, input logic [12:0] th_raw,
                              output logic [1:0] code, output logic [15:0] dw,
                              output logic [15:0] dh);
        int unsigned sw, sh, tw, th, w, h, k;
        int unsigned divs [3];
        logic [1:0]  codes [3];
        bit          found;
        divs  = '{8, 4, 2};
        codes = '{jnsr_pkg::SCALE_EIGHTH, jnsr_pkg::SCALE_QUARTER, jnsr_pkg::SCALE_HALF};
        sw = (sw_raw == 16'd0) ? 1 : 32'(sw_raw);
        sh = (sh_raw == 16'd0) ? 1 : 32'(sh_raw);
        tw = clamp_target(tw_raw);
        th = clamp_target(th_raw);
        code  = jnsr_pkg::SCALE_FULL;
        dw    = sw[15:0];
        dh    = sh[15:0];
        found = 1'b0;
        for (k = 0; k < 3; k++) begin
            w = (sw + divs[k] - 1) / divs[k];
            h = (sh + divs[k] - 1) / divs[k];
            if (!found && w >= tw && h >= th) begin
                found = 1'b1;
                code  = codes[k];
                dw    = w[15:0];
                dh    = h[15:0];
            end
        end
    endtask

    // run of target indices whose nearest source index is p
    task automatic map_span(input int unsigned p, input int unsigned d, input int unsigned t,
                            output int unsigned first_idx, output int unsigned n_hit);
        int unsigned     i;
        longint unsigned num, q;
        bit              past;
        first_idx = 0;
        n_hit     = 0;
        past      = 1'b0;
        for (i = 0; i < t && !past; i++) begin
            num = 64'(2 * i + 1) * 64'(d);
            q   = num / (64'(2) * 64'(t));
            if (q > 64'(d - 1))
                q = 64'(d - 1);
            if (q == 64'(p)) begin
                if (n_hit == 0)
                    first_idx = i;
                n_hit++;
            end else if (q > 64'(p)) begin
                past = 1'b1;
            end
        end
    endtask

    task automatic resample_item(input jnsr_pkg::t_in_item it);
        jnsr_pkg::t_out_item beat;
        int unsigned         tw, th, x0, nx, y0, ny, xi, yi;
        longint unsigned     total, emit, k;
        bit                  cut;
        beat = '0;
        beat.result_kind = jnsr_pkg::KIND_REPORT;
        if (it.req_type == jnsr_pkg::REQ_FRAME) begin
            pick_scale(src_w, src_h, tgt_w, tgt_h, scale_now, dec_w, dec_h);
            beat.scale_code         = scale_now;
            beat.decoded_width_out  = dec_w;
            beat.decoded_height_out = dec_h;
            beat.last               = 1'b1;
            beats_due.push_back(beat);
        end else if (it.pixel_x < dec_w && it.pixel_y < dec_h) begin
            tw = clamp_target(tgt_w);
            th = clamp_target(tgt_h);
            map_span(32'(it.pixel_x), 32'(dec_w), tw, x0, nx);
            map_span(32'(it.pixel_y), 32'(dec_h), th, y0, ny);
            total = 64'(nx) * 64'(ny);
            cut   = total > 64'(WRITE_CAP);
            emit  = cut ? 64'(WRITE_CAP) : total;
            k = 0;
            for (yi = 0; yi < ny && k < emit; yi++) begin
                for (xi = 0; xi < nx && k < emit; xi++) begin
                    beat.result_kind        = jnsr_pkg::KIND_WRITE;
                    beat.scale_code         = scale_now;
                    beat.decoded_width_out  = dec_w;
                    beat.decoded_height_out = dec_h;
                    beat.target_address     = jnsr_pkg::ADDR_W'((y0 + yi) * tw + x0 + xi);
                    beat.pixel_out          = it.pixel_value;
                    beat.last               = (k + 64'd1 == emit);
                    beat.truncated          = cut;
                    beats_due.push_back(beat);
                    k++;
                end
            end
        end
    endtask

    // ---------------------------------------------------------------- checking

    task automatic flag_error(input string what);
        errors++;
        $display("tb: MISMATCH at %0t ns: %s", $realtime, what);
    endtask

    task automatic check_field(input string name, input logic [23:0] got,
                               input logic [23:0] want, input int unsigned beat_no);
        if (got !== want)
            flag_error($sformatf("beat %0d %s got 0x%0h want 0x%0h",
                                 beat_no, name, got, want));
    endtask

    // ---------------------------------------------------------------- channels

    always @(posedge clk) begin : drive_in
        jnsr_pkg::t_in_item nxt_data;
        logic               nxt_valid;
        nxt_valid = in_valid;
        nxt_data  = in_data;
        if (!rst_n) begin
            nxt_valid = 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                resample_item(in_data);
                items_in++;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid && decoder_items.size() > 0
                    && $urandom_range(99) >= in_idle_pct) begin
                nxt_data  = decoder_items.pop_front();
                nxt_valid = 1'b1;
            end
        end
        in_valid <= nxt_valid;
        in_data  <= nxt_data;
    end

    always @(posedge clk) begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= !hold_out && ($urandom_range(99) >= out_stall_pct);
    end

    // long sink hold-off so the block backs up into its input
    initial begin : hold_sink
        wait (pressure_go);
        @(posedge clk);
        hold_out <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_out <= 1'b0;
    end

    always @(posedge clk) begin : check_out
        jnsr_pkg::t_out_item want;
        int unsigned         beat_no;
        if (rst_n && out_valid && out_ready) begin
            beat_no = frames_seen + writes_seen;
            if (out_data.result_kind == jnsr_pkg::KIND_REPORT)
                frames_seen++;
            else
                writes_seen++;
            if (out_data.truncated)
                cut_writes_seen++;
            if (beats_due.size() == 0) begin
                flag_error($sformatf("beat %0d arrived with nothing expected", beat_no));
            end else begin
                want = beats_due.pop_front();
                check_field("result_kind", 24'(out_data.result_kind),
                            24'(want.result_kind), beat_no);
                check_field("scale_code", 24'(out_data.scale_code),
                            24'(want.scale_code), beat_no);
                check_field("decoded_width_out", 24'(out_data.decoded_width_out),
                            24'(want.decoded_width_out), beat_no);
                check_field("decoded_height_out", 24'(out_data.decoded_height_out),
                            24'(want.decoded_height_out), beat_no);
                check_field("target_address", out_data.target_address,
                            want.target_address, beat_no);
                check_field("pixel_out", 24'(out_data.pixel_out),
                            24'(want.pixel_out), beat_no);
                check_field("last", 24'(out_data.last), 24'(want.last), beat_no);
                check_field("truncated", 24'(out_data.truncated),
                            24'(want.truncated), beat_no);
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("tb: no beat for %0d cycles", WATCHDOG_LIMIT);
            $display("tb: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------- sequences

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        case (idx)
            jnsr_pkg::CFG_SOURCE_WIDTH:  src_w = val;
            jnsr_pkg::CFG_SOURCE_HEIGHT: src_h = val;
            jnsr_pkg::CFG_TARGET_WIDTH:  tgt_w = val[12:0];
            jnsr_pkg::CFG_TARGET_HEIGHT: tgt_h = val[12:0];
            default: ;
        endcase
    endtask

    task automatic set_sizes(input logic [15:0] sw, input logic [15:0] sh,
                             input logic [12:0] tw, input logic [12:0] th);
        write_reg(jnsr_pkg::CFG_SOURCE_WIDTH, sw);
        write_reg(jnsr_pkg::CFG_SOURCE_HEIGHT, sh);
        write_reg(jnsr_pkg::CFG_TARGET_WIDTH, {3'b000, tw});
        write_reg(jnsr_pkg::CFG_TARGET_HEIGHT, {3'b000, th});
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic queue_frame();
        jnsr_pkg::t_in_item it;
        it.req_type    = jnsr_pkg::REQ_FRAME;
        it.pixel_x     = 16'($urandom);
        it.pixel_y     = 16'($urandom);
        it.pixel_value = 16'($urandom);
        decoder_items.push_back(it);
    endtask

    task automatic queue_pixel(input logic [15:0] x, input logic [15:0] y,
                               input logic [15:0] v);
        jnsr_pkg::t_in_item it;
        it.req_type    = jnsr_pkg::REQ_PIXEL;
        it.pixel_x     = x;
        it.pixel_y     = y;
        it.pixel_value = v;
        decoder_items.push_back(it);
    endtask

    // everything sent, taken and answered, then let a dropped pixel finish
    task automatic drain();
        while (decoder_items.size() != 0 || in_valid || beats_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic random_phase(input int unsigned n_items, input bit squeeze);
        logic [15:0] sw, sh, gdw, gdh;
        logic [12:0] tw, th;
        logic [1:0]  gcode;
        int unsigned i, roll;
        if (squeeze) begin
            sw = 16'($urandom_range(1, 6));
            sh = 16'($urandom_range(1, 6));
            tw = 13'($urandom_range(16, 40));
            th = 13'($urandom_range(16, 40));
        end else begin
            case ($urandom_range(9))
                0: begin
                    sw = 16'($urandom_range(1, 4));
                    sh = 16'($urandom_range(1, 4));
                    tw = 13'($urandom_range(100, 8191));
                    th = 13'($urandom_range(100, 8191));
                end
                1: begin
                    sw = 16'($urandom_range(8000, 65535));
                    sh = 16'($urandom_range(8000, 65535));
                    tw = 13'($urandom_range(1000, 8191));
                    th = 13'($urandom_range(1, 64));
                end
                2: begin
                    sw = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(1, 50));
                    sh = 16'($urandom_range(0, 50));
                    tw = $urandom_range(0, 1) ? 13'd0 : 13'($urandom_range(1, 20));
                    th = 13'($urandom_range(0, 20));
                end
                default: begin
                    sw = 16'($urandom_range(1, 160));
                    sh = 16'($urandom_range(1, 160));
                    tw = 13'($urandom_range(1, 48));
                    th = 13'($urandom_range(1, 48));
                end
            endcase
        end
        set_sizes(sw, sh, tw, th);
        if (squeeze)
            pressure_go = 1'b1;
        // now and then keep the previous frame's decoded size
        if (squeeze || $urandom_range(7) != 0) begin
            pick_scale(sw, sh, tw, th, gcode, gdw, gdh);
            queue_frame();
        end else begin
            gdw = dec_w;
            gdh = dec_h;
        end
        for (i = 0; i < n_items; i++) begin
            roll = $urandom_range(99);
            if (roll < 85)
                queue_pixel(16'($urandom_range(0, gdw - 1)), 16'($urandom_range(0, gdh - 1)),
                            16'($urandom));
            else if (roll < 93)
                queue_pixel(16'($urandom), 16'($urandom), 16'($urandom));
            else
                queue_frame();
        end
        drain();
    endtask

    initial begin : run
        int unsigned p;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset sizes: pixel before any frame start, then an out-of-range one
        queue_pixel(16'd0, 16'd0, 16'hFFFF);
        queue_pixel(16'd1, 16'd0, 16'h0000);
        queue_frame();
        drain();
        // zero size registers act as 1
        set_sizes(16'd0, 16'd0, 13'd0, 13'd0);
        queue_frame();
        queue_pixel(16'd0, 16'd0, 16'hA5A5);
        drain();
        // largest sources, oversized target saturates
        set_sizes(16'hFFFF, 16'hFFFF, 13'h1FFF, 13'h1FFF);
        queue_frame();
        queue_pixel(16'd8191, 16'd8191, 16'h5A5A);
        queue_pixel(16'd0, 16'd0, 16'h1234);
        queue_pixel(16'hFFFF, 16'hFFFF, 16'h8001);
        drain();
        // heavy upscale: far more writes than the cap
        set_sizes(16'd1, 16'd1, 13'd4096, 13'd4096);
        queue_frame();
        queue_pixel(16'd0, 16'd0, 16'h7E0F);
        drain();
        // exactly the cap, then one write over it
        set_sizes(16'd1, 16'd1, 13'd8, 13'd8);
        queue_frame();
        queue_pixel(16'd0, 16'd0, 16'hF800);
        drain();
        set_sizes(16'd1, 16'd1, 13'd13, 13'd5);
        queue_frame();
        queue_pixel(16'd0, 16'd0, 16'h001F);
        drain();
        // half, quarter, and half forced by height alone
        set_sizes(16'd40, 16'd40, 13'd15, 13'd15);
        queue_frame();
        queue_pixel(16'd19, 16'd19, 16'h0F0F);
        drain();
        set_sizes(16'd40, 16'd40, 13'd8, 13'd8);
        queue_frame();
        queue_pixel(16'd9, 16'd0, 16'hF0F0);
        drain();
        set_sizes(16'd64, 16'd16, 13'd8, 13'd8);
        queue_frame();
        queue_pixel(16'd31, 16'd7, 16'h3C3C);
        drain();
        // target changed after the frame start: old decoded size, new target
        set_sizes(16'd100, 16'd100, 13'd10, 13'd10);
        queue_frame();
        drain();
        set_sizes(16'd100, 16'd100, 13'd50, 13'd20);
        queue_pixel(16'd12, 16'd12, 16'hC3C3);
        queue_pixel(16'd0, 16'd5, 16'h0001);
        drain();

        for (p = 0; p < 10; p++) begin
            case (p % 4)
                0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
                1: begin in_idle_pct = 74; out_stall_pct = 0;  end
                2: begin in_idle_pct = 0;  out_stall_pct = 74; end
                default: begin in_idle_pct = 6; out_stall_pct = 6; end
            endcase
            if (p == 4) begin
                in_idle_pct   = 0;
                out_stall_pct = 0;
            end
            random_phase(21, p == 4);
        end

        if (beats_due.size() != 0)
            flag_error($sformatf("%0d beats never arrived", beats_due.size()));
        $display("tb: %0d decoder items taken, %0d frame reports and %0d buffer writes checked",
                 items_in, frames_seen, writes_seen);
        $display("tb: %0d writes carried the truncation flag; idle, stall, backpressure run",
                 cut_writes_seen);
        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
